/* hdl/rmf_pkg.sv */
package rmf_pkg;

	localparam int MAX_WINDOW   = 31;
	localparam int SAMPLE_WIDTH = 32;
	localparam int CFG_W        = 5;
	localparam int IDX_W        = $clog2(MAX_WINDOW + 1);
	localparam int SEL_W        = $clog2(MAX_WINDOW);

	// what one cell shows its neighbors
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] val;
		logic [IDX_W-1:0]               age;
		logic                           lt;
		logic                           dp;
	} link_t;

	// shared control broadcast to every cell
	typedef struct packed {
		logic                           upd;
		logic                           full;
		logic [IDX_W-1:0]               last_age;
		logic signed [SAMPLE_WIDTH-1:0] x;
	} ctrl_t;

	// odd window length, limited to 1..MAX_WINDOW
	function automatic logic [IDX_W-1:0] eff_window(input logic [CFG_W-1:0] ws);
		logic [CFG_W-1:0] sz;
		logic [IDX_W-1:0] res;
		sz = ws;
		if (sz == '0) begin
			res = IDX_W'(1);
		end else begin
			if (!sz[0]) begin
				sz = sz - CFG_W'(1);
			end
			if (int'(sz) > MAX_WINDOW) begin
				res = IDX_W'(1);
			end else begin
				res = IDX_W'(sz);
			end
		end
		return res;
	endfunction

endpackage

/* hdl/running_median_filter.sv */
// running median filter over signed samples
// input channel: sample with sample_valid / sample_stall; a transaction is
// taken at a rising edge with sample_valid high and sample_stall low
// output channel: filtered and window_full with result_valid / result_stall
// configuration: cfg_we with cfg_data writes window_size and empties the
// window; write only while no transaction is in flight
// the window is kept as a row of cells sorted by value, each with an age;
// every accepted sample, window above one, removes the oldest cell (once
// full) and is inserted in place in the same cycle; the median cell is
// picked from the row; a result is valid in the cycle after its input
// throughput: one sample per cycle while the output is not stalled, as
// the cell row inserts combinationally ahead of the output register
// reset: window_size is 1, the window is empty, no result is pending
// a stalled result holds in the output register; the input is stalled
// only while that register is full and the receiver stalls
module running_median_filter (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [rmf_pkg::CFG_W-1:0]               cfg_data,
	input  logic                                    sample_valid,
	output logic                                    sample_stall,
	input  logic signed [rmf_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic                                    result_valid,
	input  logic                                    result_stall,
	output logic signed [rmf_pkg::SAMPLE_WIDTH-1:0] filtered,
	output logic                                    window_full
);

	logic [rmf_pkg::CFG_W-1:0]               ws_q;
	logic [rmf_pkg::IDX_W-1:0]               count_q;
	logic                                    res_valid_q;
	logic signed [rmf_pkg::SAMPLE_WIDTH-1:0] filtered_q;
	logic                                    full_flag_q;

	logic [rmf_pkg::IDX_W-1:0]               win;
	logic [rmf_pkg::IDX_W-1:0]               half;
	logic                                    accept;
	logic                                    single;
	logic                                    full;
	rmf_pkg::ctrl_t                          ctrl;
	rmf_pkg::link_t                          links [rmf_pkg::MAX_WINDOW];
	logic signed [rmf_pkg::SAMPLE_WIDTH-1:0] nxt_vals [rmf_pkg::MAX_WINDOW];

	// handshake and window control
	always_comb begin
		win          = rmf_pkg::eff_window(ws_q);
		half         = win >> 1;
		single       = (win == rmf_pkg::IDX_W'(1));
		full         = (count_q == win);
		sample_stall = res_valid_q && result_stall;
		accept       = sample_valid && !sample_stall;
		ctrl.upd      = accept && !single;
		ctrl.full     = full;
		ctrl.last_age = win - rmf_pkg::IDX_W'(1);
		ctrl.x        = sample;
	end

	// sorted cell row
	for (genvar i = 0; i < rmf_pkg::MAX_WINDOW; i++) begin : g_cell
		rmf_pkg::link_t prev_l, next_l;
		logic           cell_valid;

		assign cell_valid = (rmf_pkg::IDX_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign prev_l = '0;
		end else begin : g_mid
			assign prev_l = links[i-1];
		end

		if (i == rmf_pkg::MAX_WINDOW - 1) begin : g_last
			assign next_l = '0;
		end else begin : g_inner
			assign next_l = links[i+1];
		end

		rmf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.valid   (cell_valid),
			.first   (i == 0),
			.prev    (prev_l),
			.next    (next_l),
			.self    (links[i]),
			.nxt_val (nxt_vals[i])
		);
	end

	// window size and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= rmf_pkg::CFG_W'(1);
			count_q <= '0;
		end else if (cfg_we) begin
			ws_q    <= cfg_data;
			count_q <= '0;
		end else if (ctrl.upd && !full) begin
			count_q <= count_q + rmf_pkg::IDX_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (single || !full) begin
				filtered_q <= sample;
			end else begin
				filtered_q <= nxt_vals[half[rmf_pkg::SEL_W-1:0]];
			end
			full_flag_q <= single || full;
		end
	end

	assign result_valid = res_valid_q;
	assign filtered     = filtered_q;
	assign window_full  = full_flag_q;

endmodule

/* hdl/rmf_cell.sv */
module rmf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  rmf_pkg::ctrl_t     ctrl,
	input  logic               valid,
	input  logic               first,
	input  rmf_pkg::link_t     prev,
	input  rmf_pkg::link_t     next,
	output rmf_pkg::link_t     self,
	output logic signed [rmf_pkg::SAMPLE_WIDTH-1:0] nxt_val
);

	logic signed [rmf_pkg::SAMPLE_WIDTH-1:0] val_q;
	logic [rmf_pkg::IDX_W-1:0]               age_q;
	logic                                    is_old;
	logic                                    b_lt, pb_lt;
	logic signed [rmf_pkg::SAMPLE_WIDTH-1:0] b_val, pb_val;
	logic [rmf_pkg::IDX_W-1:0]               b_age, pb_age, nxt_age;

	// own compare against the new sample and the oldest-entry mark
	always_comb begin
		is_old   = ctrl.full && valid && (age_q == ctrl.last_age);
		self.val = val_q;
		self.age = age_q;
		self.lt  = valid && (val_q < ctrl.x);
		self.dp  = (first ? 1'b0 : prev.dp) | is_old;
	end

	// list with the oldest entry taken out, at this cell and the one before
	always_comb begin
		b_val  = self.dp ? next.val : val_q;
		b_age  = self.dp ? next.age : age_q;
		b_lt   = self.dp ? next.lt  : self.lt;
		pb_val = prev.dp ? val_q    : prev.val;
		pb_age = prev.dp ? age_q    : prev.age;
		pb_lt  = first ? 1'b1 : (prev.dp ? self.lt : prev.lt);
	end

	// insert the new sample in sorted order
	always_comb begin
		if (b_lt) begin
			nxt_val = b_val;
			nxt_age = b_age + rmf_pkg::IDX_W'(1);
		end else if (pb_lt) begin
			nxt_val = ctrl.x;
			nxt_age = '0;
		end else begin
			nxt_val = pb_val;
			nxt_age = pb_age + rmf_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (ctrl.upd) begin
			age_q <= nxt_age;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			val_q <= nxt_val;
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 930;

	typedef logic signed [rmf_pkg::SAMPLE_WIDTH-1:0] sample_t;

	// one expected output transaction
	typedef struct packed {
		sample_t filtered;
		logic    window_full;
	} median_result_t;

	logic                      clk;
	logic                      arst_n       = 1'b0;
	logic                      cfg_we       = 1'b0;
	logic [rmf_pkg::CFG_W-1:0] cfg_data     = '0;
	logic                      sample_valid = 1'b0;
	logic                      sample_stall;
	sample_t                   sample       = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	sample_t                   filtered;
	logic                      window_full;

	// predictor state
	sample_t             window_vals [rmf_pkg::MAX_WINDOW];
	int                  cur_size     = 1;
	int                  ring_slot    = 0;
	int                  fill_level   = 0;

	median_result_t      median_queue [$];
	int                  mismatch_count = 0;
	int                  cycle_count    = 0;
	int                  items_sent     = 0;
	bit                  idle_on        = 1'b0;
	bit                  stall_on       = 1'b0;
	int                  stall_left     = 0;

	running_median_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.filtered     (filtered),
		.window_full  (window_full)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// odd window length in 1..MAX_WINDOW
	function automatic int window_len(int req);
		int sz;
		sz = req;
		if (sz == 0)
			return 1;
		if (sz % 2 == 0)
			sz = sz - 1;
		if (sz < 1 || sz > rmf_pkg::MAX_WINDOW)
			return 1;
		return sz;
	endfunction

	// advance the predictor by one sample and return the expected output
	function automatic median_result_t predict_median(sample_t s);
		median_result_t res;
		int n;
		int slot;
		int rank;
		n = window_len(cur_size);
		res.filtered = s;
		res.window_full = 1'b0;
		if (n == 1) begin
			res.window_full = 1'b1;
			return res;
		end
		slot = ring_slot;
		if (slot >= n)
			slot = 0;
		window_vals[slot] = s;
		slot++;
		if (slot >= n)
			slot = 0;
		ring_slot = slot;
		if (fill_level < n) begin
			fill_level++;
			return res;
		end
		// rank each entry, ties broken by slot number
		for (int i = 0; i < n; i++) begin
			rank = 0;
			for (int j = 0; j < n; j++) begin
				if (window_vals[j] < window_vals[i] ||
					(window_vals[j] == window_vals[i] && j < i))
					rank++;
			end
			if (rank == n / 2)
				res.filtered = window_vals[i];
		end
		res.window_full = 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// monitor: check output transactions, predict input transactions
	always @(posedge clk) begin
		median_result_t got;
		median_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got.filtered = filtered;
				got.window_full = window_full;
				if (median_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected result filtered=%0d window_full=%0b",
						got.filtered, got.window_full));
				end else begin
					want = median_queue.pop_front();
					if (got.filtered !== want.filtered)
						report_mismatch($sformatf("filtered %0d, expected %0d",
							got.filtered, want.filtered));
					if (got.window_full !== want.window_full)
						report_mismatch($sformatf("window_full %0b, expected %0b",
							got.window_full, want.window_full));
				end
			end
			if (cfg_we) begin
				cur_size = int'(cfg_data);
				ring_slot = 0;
				fill_level = 0;
			end
			if (sample_valid && !sample_stall)
				median_queue.push_back(predict_median(sample));
		end
	end

	// receiver stall pattern: mostly short bursts, a few long ones
	always @(negedge clk) begin
		int pick;
		if (stall_left > 0) begin
			stall_left--;
			result_stall = 1'b1;
		end else if (!stall_on) begin
			result_stall = 1'b0;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				result_stall = 1'b0;
			end else if (pick < 95) begin
				result_stall = 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				result_stall = 1'b1;
				stall_left = $urandom_range(8, 25);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[running_median_filter] ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int pick;
		if (!idle_on)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// one input transaction, entered and left at a falling edge
	task automatic send_sample(sample_t v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample = v;
		sample_valid = 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// let every pending result drain and hold sample_valid low
	task automatic wait_idle();
		sample_valid = 1'b0;
		while (median_queue.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_window(int code);
		wait_idle();
		cfg_data = rmf_pkg::CFG_W'(code);
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic sample_t make_sample(int style, int k, sample_t base, int stride);
		case (style)
			0: return sample_t'($urandom);
			1: return sample_t'($urandom_range(0, 8)) - sample_t'(4);
			2: begin
				case ($urandom_range(0, 5))
					0: return {1'b1, {(rmf_pkg::SAMPLE_WIDTH-1){1'b0}}};
					1: return {1'b0, {(rmf_pkg::SAMPLE_WIDTH-1){1'b1}}};
					2: return '0;
					3: return '1;
					4: return sample_t'(1);
					default: return sample_t'($urandom);
				endcase
			end
			default: return base + sample_t'(k * stride);
		endcase
	endfunction

	// reset window of one: extremes pass straight through
	task automatic test_reset_passthrough();
		send_sample({1'b1, {(rmf_pkg::SAMPLE_WIDTH-1){1'b0}}});
		send_sample({1'b0, {(rmf_pkg::SAMPLE_WIDTH-1){1'b1}}});
		send_sample('0);
		send_sample('1);
	endtask

	// zero and two both collapse to a window of one
	task automatic test_window_rules();
		set_window(0);
		send_sample(sample_t'(123));
		send_sample(sample_t'(-77));
		set_window(2);
		send_sample(sample_t'(-5));
		send_sample(sample_t'(9));
	endtask

	// four gives three: fill, then medians with extremes and ties
	task automatic test_even_to_odd();
		set_window(4);
		send_sample(sample_t'(5));
		send_sample(sample_t'(-3));
		send_sample(sample_t'(7));
		send_sample({1'b0, {(rmf_pkg::SAMPLE_WIDTH-1){1'b1}}});
		send_sample({1'b1, {(rmf_pkg::SAMPLE_WIDTH-1){1'b0}}});
		send_sample(sample_t'(7));
		send_sample(sample_t'(7));
	endtask

	// equal samples across a window of five
	task automatic test_equal_samples();
		set_window(5);
		repeat (7) send_sample(sample_t'(-1));
	endtask

	// random phases of window setting, sample shape and idling
	task automatic test_random_phases();
		int code;
		int len;
		int style;
		int stride;
		sample_t base;
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: code = 31;
				1: code = 30;
				2: code = $urandom_range(0, 2);
				3, 4: code = $urandom_range(0, 31);
				default: code = $urandom_range(3, 9);
			endcase
			idle_on = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			set_window(code);
			len = window_len(code) + $urandom_range(5, 60);
			style = $urandom_range(0, 3);
			base = sample_t'($urandom);
			stride = $urandom_range(0, 2000) - 1000;
			for (int k = 0; k < len && items_sent - start < RANDOM_ITEMS; k++)
				send_sample(make_sample(style, k, base, stride));
		end
		idle_on = 1'b0;
		stall_on = 1'b0;
	endtask

	// test sequence
	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		idle_on = 1'b1;
		stall_on = 1'b1;
		test_reset_passthrough();
		test_window_rules();
		test_even_to_odd();
		test_equal_samples();
		test_random_phases();
		wait_idle();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("[running_median_filter] OK");
		end else begin
			$display("[running_median_filter] ERROR");
		end
		$finish;
	end

endmodule

/* running_median_filter.f */
hdl/rmf_pkg.sv
hdl/rmf_cell.sv
hdl/running_median_filter.sv
tb/testbench.sv
